/* hw/rtl/pgb_pkg.sv */
// Shared types, constants and helpers for the packed gray blit block.
package pgb_pkg;

    // Framebuffer size limits used by the bounds flag
    localparam int MAX_FB_COLS   = 2048;
    localparam int MAX_FB_HEIGHT = 2048;

    // Configuration register indexes
    localparam logic [2:0] REG_FB_COLS     = 3'd0;
    localparam logic [2:0] REG_FB_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_DEST_X      = 3'd2;
    localparam logic [2:0] REG_DEST_Y      = 3'd3;
    localparam logic [2:0] REG_BLIT_WIDTH  = 3'd4;
    localparam logic [2:0] REG_BLIT_HEIGHT = 3'd5;
    localparam logic [2:0] REG_PIXEL_DEPTH = 3'd6;

    // Pixel depth codes
    localparam logic DEPTH_1BPP = 1'b0;
    localparam logic DEPTH_2BPP = 1'b1;

    // Gray levels
    localparam logic [3:0] GRAY_BLACK = 4'h0;
    localparam logic [3:0] GRAY_DARK  = 4'h8;
    localparam logic [3:0] GRAY_LIGHT = 4'hD;
    localparam logic [3:0] GRAY_WHITE = 4'hF;

    // Configuration register bank
    typedef struct packed {
        logic [11:0] fb_cols;
        logic [11:0] fb_height;
        logic [10:0] dest_x;
        logic [10:0] dest_y;
        logic [11:0] blit_width;
        logic [11:0] blit_height;
        logic        pixel_depth;
    } t_cfg;

    // One source byte ready for expansion
    typedef struct packed {
        logic [7:0]  src_byte;
        logic [11:0] col0;
        logic [3:0]  count;
        logic [20:0] row_base;
        logic        row_oob;
        logic        row_last;
        logic        depth;
    } t_job;

    // 2-bit code to 4-bit gray
    function automatic logic [3:0] gray2(input logic [1:0] code);
        logic [3:0] g;
        case (code)
            2'd0:    g = GRAY_BLACK;
            2'd1:    g = GRAY_DARK;
            2'd2:    g = GRAY_LIGHT;
            default: g = GRAY_WHITE;
        endcase
        return g;
    endfunction

endpackage

/* hw/rtl/pgb_cfg_regs.sv */
// Configuration register bank written through the plain write port.
module pgb_cfg_regs import pgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FB_COLS:     r_cfg.fb_cols     <= i_cfg_wdata;
                REG_FB_HEIGHT:   r_cfg.fb_height   <= i_cfg_wdata;
                REG_DEST_X:      r_cfg.dest_x      <= i_cfg_wdata[10:0];
                REG_DEST_Y:      r_cfg.dest_y      <= i_cfg_wdata[10:0];
                REG_BLIT_WIDTH:  r_cfg.blit_width  <= i_cfg_wdata;
                REG_BLIT_HEIGHT: r_cfg.blit_height <= i_cfg_wdata;
                REG_PIXEL_DEPTH: r_cfg.pixel_depth <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/pgb_walker.sv */
// Rectangle walker: column/row counters, row address multiply, job build.
module pgb_walker import pgb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_accept,
    input  logic [7:0] i_src_byte,
    output logic  o_load,
    output t_job  o_job
);

    logic [11:0] r_col, r_row;
    logic [11:0] n_col, n_row;

    logic        empty, stale;
    logic [11:0] c_eff, r_eff, remain;
    logic [3:0]  per_byte, count;
    logic [12:0] py, col_sum, row_inc;
    logic [10:0] pitch;
    logic [23:0] prod;

    // Restart the walk when the counters lie outside the rectangle
    assign empty  = (i_cfg.blit_width == '0) || (i_cfg.blit_height == '0);
    assign stale  = (r_col >= i_cfg.blit_width) || (r_row >= i_cfg.blit_height);
    assign c_eff  = stale ? '0 : r_col;
    assign r_eff  = stale ? '0 : r_row;

    // Pixels taken from this byte
    assign per_byte = (i_cfg.pixel_depth == DEPTH_2BPP) ? 4'd4 : 4'd8;
    assign remain   = i_cfg.blit_width - c_eff;
    assign count    = (remain > 12'(per_byte)) ? per_byte : remain[3:0];

    // Row start address and row bounds
    assign py    = 13'(i_cfg.dest_y) + 13'(r_eff);
    assign pitch = i_cfg.fb_cols[11:1];
    assign prod  = 24'(py) * 24'(pitch);
    assign row_inc = 13'(r_eff) + 13'd1;

    always_comb begin
        o_job.src_byte = i_src_byte;
        o_job.col0     = c_eff;
        o_job.count    = count;
        o_job.row_base = prod[20:0];
        o_job.row_oob  = (py >= 13'(i_cfg.fb_height))
                      || ({1'b0, py} >= 14'(MAX_FB_HEIGHT));
        o_job.row_last = (row_inc == 13'(i_cfg.blit_height));
        o_job.depth    = i_cfg.pixel_depth;
    end

    assign o_load = i_accept && !empty;

    // Counter advance at the end of each byte
    assign col_sum = 13'(c_eff) + 13'(count);
    always_comb begin
        n_col = col_sum[11:0];
        n_row = r_eff;
        if (col_sum >= 13'(i_cfg.blit_width)) begin
            n_col = '0;
            n_row = (row_inc >= 13'(i_cfg.blit_height)) ? '0 : row_inc[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_load) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

/* hw/rtl/pgb_expand.sv */
// Pixel expander: one nibble write per cycle from the held byte unless stalled, output register.
module pgb_expand import pgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_load,
    input  t_job        i_job,
    output logic        o_take,
    input  logic        i_pix_stall,
    output logic        o_pix_valid,
    output logic [20:0] o_fb_addr,
    output logic        o_high_nibble,
    output logic [3:0]  o_gray_level,
    output logic        o_out_of_range,
    output logic        o_last_of_byte,
    output logic        o_last_of_blit
);

    t_job        r_job;
    logic        r_busy;
    logic [2:0]  r_k;
    logic        r_out_valid;
    logic [20:0] r_addr;
    logic        r_high, r_oob, r_lbyte, r_lblit;
    logic [3:0]  r_gray;

    logic        advance, emit, last;
    logic [11:0] col;
    logic [12:0] px, col_inc;
    logic [3:0]  gray;
    logic [1:0]  code;

    // Handshake between held byte and output register
    assign advance = !r_out_valid || !i_pix_stall;
    assign emit    = r_busy && advance;
    assign last    = (4'(r_k) + 4'd1) == r_job.count;
    assign o_take  = !r_busy || (emit && last);

    // Current pixel position
    assign col     = r_job.col0 + 12'(r_k);
    assign px      = 13'(i_cfg.dest_x) + 13'(col);
    assign col_inc = 13'(col) + 13'd1;

    // Gray expansion, leftmost pixel in the top bits
    always_comb begin
        case (r_k[1:0])
            2'd0:    code = r_job.src_byte[7:6];
            2'd1:    code = r_job.src_byte[5:4];
            2'd2:    code = r_job.src_byte[3:2];
            default: code = r_job.src_byte[1:0];
        endcase
        if (r_job.depth == DEPTH_2BPP) begin
            gray = gray2(code);
        end else begin
            gray = r_job.src_byte[3'd7 - r_k] ? GRAY_BLACK : GRAY_WHITE;
        end
    end

    // Byte hold register and pixel index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else begin
            if (emit) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_addr  <= r_job.row_base + 21'(px[12:1]);
            r_high  <= px[0];
            r_gray  <= gray;
            r_oob   <= r_job.row_oob || (px >= 13'(i_cfg.fb_cols))
                    || ({1'b0, px} >= 14'(MAX_FB_COLS));
            r_lbyte <= last;
            r_lblit <= (col_inc == 13'(i_cfg.blit_width)) && r_job.row_last;
        end
    end

    assign o_pix_valid    = r_out_valid;
    assign o_fb_addr      = r_addr;
    assign o_high_nibble  = r_high;
    assign o_gray_level   = r_gray;
    assign o_out_of_range = r_oob;
    assign o_last_of_byte = r_lbyte;
    assign o_last_of_blit = r_lblit;

endmodule

/* hw/rtl/packed_gray_blit_to_nibble_fb.sv */
// Top level of the packed 1/2-bit to 4-bit gray framebuffer blit.
//
//  Channel | Direction | Handshake                | Payload
//  src     | in        | i_src_valid / o_src_stall | i_src_byte
//  pix     | out       | o_pix_valid / i_pix_stall | o_fb_addr, o_high_nibble, o_gray_level,
//          |           |                           | o_out_of_range, o_last_of_byte,
//          |           |                           | o_last_of_blit
//  cfg     | in        | i_cfg_we                  | i_cfg_index, i_cfg_wdata
//
// One pixel write leaves per cycle while i_pix_stall is low; a byte holds up to 8
// pixels in 1-bit mode, up to 4 in 2-bit mode, fewer at a row end.
// The single-byte hold register in the expander sets the pace; the next byte is
// taken in the cycle its predecessor's last pixel moves to the output register.
// A byte's first pixel passes the hold register, then the output register.
// Synchronous active-low reset clears counters and valids; a pixel stall holds
// the output register and back-pressures src.
module packed_gray_blit_to_nibble_fb import pgb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_src_valid,
    output logic        o_src_stall,
    input  logic [7:0]  i_src_byte,
    output logic        o_pix_valid,
    input  logic        i_pix_stall,
    output logic [20:0] o_fb_addr,
    output logic        o_high_nibble,
    output logic [3:0]  o_gray_level,
    output logic        o_out_of_range,
    output logic        o_last_of_byte,
    output logic        o_last_of_blit
);

    t_cfg cfg;
    t_job job;
    logic take, load;

    pgb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Source transfer whenever the expander can take a byte
    assign o_src_stall = !take;

    pgb_walker u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (i_src_valid && take),
        .i_src_byte (i_src_byte),
        .o_load     (load),
        .o_job      (job)
    );

    pgb_expand u_exp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_load         (load),
        .i_job          (job),
        .o_take         (take),
        .i_pix_stall    (i_pix_stall),
        .o_pix_valid    (o_pix_valid),
        .o_fb_addr      (o_fb_addr),
        .o_high_nibble  (o_high_nibble),
        .o_gray_level   (o_gray_level),
        .o_out_of_range (o_out_of_range),
        .o_last_of_byte (o_last_of_byte),
        .o_last_of_blit (o_last_of_blit)
    );

endmodule

/* hw/rtl/pgb_checker.sv */
// Port-level checker for the blit block, bound to the top level.
module pgb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_src_valid,
    input  logic        o_src_stall,
    input  logic        o_pix_valid,
    input  logic        i_pix_stall,
    input  logic [20:0] o_fb_addr,
    input  logic        o_high_nibble,
    input  logic [3:0]  o_gray_level,
    input  logic        o_out_of_range,
    input  logic        o_last_of_byte,
    input  logic        o_last_of_blit
);

    // A stalled pixel holds its payload
    a_pix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_valid && i_pix_stall |=> o_pix_valid && $stable(o_fb_addr)
            && $stable(o_high_nibble) && $stable(o_gray_level)
            && $stable(o_out_of_range) && $stable(o_last_of_byte)
            && $stable(o_last_of_blit))
        else $error("pixel payload changed under stall");

    // A stalled source byte stays offered
    a_src_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_src_valid && o_src_stall |=> i_src_valid)
        else $error("source transfer withdrawn under stall");

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix_valid)
        else $error("pixel valid after reset");

    // The last pixel of the rectangle also closes its byte
    a_blit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_valid && o_last_of_blit |-> o_last_of_byte)
        else $error("blit ended mid-byte");

    // Pixels of one byte follow without a gap, alternating nibbles
    a_byte_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_valid && !i_pix_stall && !o_last_of_byte
            |=> o_pix_valid && (o_high_nibble != $past(o_high_nibble)))
        else $error("gap or nibble repeat inside a byte");

endmodule

bind packed_gray_blit_to_nibble_fb pgb_checker u_pgb_checker (.*);
